@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/blci_pkg.sv @@
// Shared types, constants and helpers for the battery level interpolator.
`default_nettype none

package blci_pkg;

    localparam int MAX_POINTS = 16;

    localparam int VOLT_W = 16;
    localparam int LVL_W  = 8;
    localparam int OUT_W  = 7;
    localparam int IDX_W  = 4;
    localparam int ACT_W  = 2;
    localparam int CFG_W  = 5;
    localparam int CFG_IDX_W = 1;

    localparam int PT_W   = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int ADDR_W = PT_W + 1;
    localparam int DEPTH  = 2 * MAX_POINTS;
    localparam int WORD_W = VOLT_W + LVL_W;

    localparam int DL_W   = LVL_W + 1;
    localparam int DV_W   = VOLT_W + 1;
    localparam int PROD_W = DL_W + DV_W;
    localparam int NUM_W  = LVL_W + VOLT_W;
    localparam int ACC_W  = NUM_W + 2;
    localparam int STEP_W = $clog2(NUM_W);

    localparam int LEVEL_MAX = 100;

    localparam logic [ACT_W-1:0] ACT_WR_CHARGE    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WR_DISCHARGE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY        = 2'd2;
    localparam logic [ACT_W-1:0] ACT_NONE         = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_POINTS    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCHARGE_POINTS = 1'd1;

    localparam logic CURVE_CHARGE    = 1'b1;
    localparam logic CURVE_DISCHARGE = 1'b0;

    typedef struct packed {
        logic             wr_en;
        logic             ld_query;
        logic             rd_en;
        logic [PT_W-1:0]  rd_idx;
        logic             cap_first;
        logic             cap_last;
        logic             scan;
        logic             mul;
        logic             div_init;
        logic             div_step;
        logic             fin;
        logic             out_load;
    } t_cmd;

    typedef struct packed {
        logic less;
        logic span_zero;
    } t_status;

    // Point count as used: zero reads as one, anything above the table depth saturates.
    function automatic logic [CNT_W-1:0] f_eff_count(input logic [CFG_W-1:0] cnt);
        logic [CNT_W-1:0] res;
        if (cnt == '0) begin
            res = CNT_W'(1);
        end else if (32'(cnt) > 32'(MAX_POINTS)) begin
            res = CNT_W'(MAX_POINTS);
        end else begin
            res = CNT_W'(cnt);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ hdl/blci_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module blci_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/blci_datapath.sv @@
// Datapath: point RAM, clamp, segment scan, multiplier and restoring divider.
`default_nettype none

module blci_datapath
    import blci_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire t_cmd                    i_cmd,
    input  wire logic [ACT_W-1:0]        i_action,
    input  wire logic [IDX_W-1:0]        i_point_index,
    input  wire logic [VOLT_W-1:0]       i_point_voltage,
    input  wire logic signed [LVL_W-1:0] i_point_level,
    input  wire logic [VOLT_W-1:0]       i_query_voltage,
    input  wire logic                    i_charging,
    output t_status                      o_status,
    output logic [OUT_W-1:0]             o_level
);

    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_ok;
    logic              rd_curve;
    logic [WORD_W-1:0] rd_data;
    logic [VOLT_W-1:0] rd_v;
    logic signed [LVL_W-1:0] rd_l;

    logic                     r_curve;
    logic [VOLT_W-1:0]        r_v;
    logic [VOLT_W-1:0]        r_prev_v;
    logic signed [LVL_W-1:0]  r_prev_l;
    logic signed [ACC_W-1:0]  r_level;
    logic signed [DL_W-1:0]   r_dl;
    logic signed [DV_W-1:0]   r_dv;
    logic signed [DV_W-1:0]   r_span;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_neg;
    logic [NUM_W-1:0]         r_num;
    logic [VOLT_W-1:0]        r_den;
    logic [VOLT_W-1:0]        r_rem;
    logic [OUT_W-1:0]         r_out_level;

    logic signed [PROD_W-1:0] prod_abs;
    logic signed [DV_W-1:0]   span_abs;
    logic [VOLT_W:0]          rem_sh;
    logic                     q_bit;
    logic signed [ACC_W-1:0]  q_ext;
    logic [VOLT_W-1:0]        v_clamped;
    logic [OUT_W-1:0]         level_clamped;

    // Write address: curve bit on top of the point position.
    assign wr_ok    = 32'(i_point_index) < 32'(MAX_POINTS);
    assign wr_addr  = {(i_action == ACT_WR_CHARGE) ? CURVE_CHARGE : CURVE_DISCHARGE,
                       PT_W'(i_point_index)};
    assign rd_curve = i_cmd.ld_query ? i_charging : r_curve;
    assign rd_addr  = {rd_curve, i_cmd.rd_idx};

    blci_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en && wr_ok),
        .i_wr_addr (wr_addr),
        .i_wr_data ({i_point_voltage, i_point_level}),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign rd_v = rd_data[WORD_W-1:LVL_W];
    assign rd_l = $signed(rd_data[LVL_W-1:0]);

    assign o_status.less      = r_v < rd_v;
    assign o_status.span_zero = (r_span == '0);

    always_comb begin
        // clamp to first point (held in prev) and last point (on the read port)
        if (r_v < r_prev_v) begin
            v_clamped = r_prev_v;
        end else if (r_v > rd_v) begin
            v_clamped = rd_v;
        end else begin
            v_clamped = r_v;
        end

        prod_abs = r_prod[PROD_W-1] ? -r_prod : r_prod;
        span_abs = r_span[DV_W-1] ? -r_span : r_span;

        rem_sh = {r_rem, r_num[NUM_W-1]};
        q_bit  = rem_sh >= {1'b0, r_den};
        q_ext  = $signed({2'b00, r_num});

        if (r_level < 0) begin
            level_clamped = '0;
        end else if (r_level > $signed(ACC_W'(LEVEL_MAX))) begin
            level_clamped = OUT_W'(LEVEL_MAX);
        end else begin
            level_clamped = r_level[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_query) begin
            r_v     <= i_query_voltage;
            r_curve <= i_charging;
        end
        if (i_cmd.cap_first) begin
            r_prev_v <= rd_v;
            r_prev_l <= rd_l;
            r_level  <= ACC_W'(rd_l);
        end
        if (i_cmd.cap_last) begin
            r_v <= v_clamped;
        end
        if (i_cmd.scan) begin
            if (o_status.less) begin
                r_dl   <= DL_W'(rd_l) - DL_W'(r_prev_l);
                r_dv   <= $signed({1'b0, r_v}) - $signed({1'b0, r_prev_v});
                r_span <= $signed({1'b0, rd_v}) - $signed({1'b0, r_prev_v});
            end else begin
                r_prev_v <= rd_v;
                r_prev_l <= rd_l;
                r_level  <= ACC_W'(rd_l);
            end
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_dl) * PROD_W'(r_dv);
            r_neg  <= r_dl[DL_W-1] ^ r_dv[DV_W-1] ^ r_span[DV_W-1];
        end
        if (i_cmd.div_init) begin
            r_num <= prod_abs[NUM_W-1:0];
            r_den <= span_abs[VOLT_W-1:0];
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= q_bit ? VOLT_W'(rem_sh - {1'b0, r_den}) : rem_sh[VOLT_W-1:0];
            r_num <= {r_num[NUM_W-2:0], q_bit};
        end
        if (i_cmd.fin) begin
            r_level <= ACC_W'(r_prev_l) + (r_neg ? -q_ext : q_ext);
        end
        if (i_cmd.out_load) begin
            r_out_level <= level_clamped;
        end
    end

    assign o_level = r_out_level;

endmodule

`default_nettype wire

@@ hdl/blci_ctrl.sv @@
// Controller: sequences writes, the point scan and the divide; owns the handshakes.
`default_nettype none

module blci_ctrl
    import blci_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [ACT_W-1:0] i_action,
    input  wire logic [CNT_W-1:0] i_n,
    input  wire t_status          i_status,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_cmd                  o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FIRST = 4'd1;
    localparam logic [3:0] S_LAST  = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_INIT  = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_n, n_n;
    logic [CNT_W-1:0]  r_i, n_i;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic              accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_i     = r_i;
        n_step  = r_step;
        o_cmd   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_action)
                        ACT_WR_CHARGE, ACT_WR_DISCHARGE: begin
                            o_cmd.wr_en = 1'b1;
                        end
                        ACT_QUERY: begin
                            o_cmd.ld_query = 1'b1;
                            o_cmd.rd_en    = 1'b1;
                            o_cmd.rd_idx   = '0;
                            n_n            = i_n;
                            n_state        = S_FIRST;
                        end
                        ACT_NONE: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FIRST: begin
                o_cmd.cap_first = 1'b1;
                o_cmd.rd_en     = 1'b1;
                o_cmd.rd_idx    = PT_W'(r_n - 1'b1);
                n_state         = S_LAST;
            end
            S_LAST: begin
                o_cmd.cap_last = 1'b1;
                if (r_n == CNT_W'(1)) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_idx = PT_W'(1);
                    n_i          = CNT_W'(1);
                    n_state      = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.less) begin
                    n_state = S_MUL;
                end else if (r_i == CNT_W'(r_n - 1'b1)) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_idx = PT_W'(r_i + 1'b1);
                    n_i          = CNT_W'(r_i + 1'b1);
                end
            end
            S_MUL: begin
                // zero span keeps the lower point's level
                if (i_status.span_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.mul = 1'b1;
                    n_state   = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.div_init = 1'b1;
                n_step         = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = STEP_W'(r_step + 1'b1);
                if (r_step == STEP_W'(NUM_W - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_n         <= CNT_W'(1);
            r_i         <= '0;
            r_step      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_n         <= n_n;
            r_i         <= n_i;
            r_step      <= n_step;
        end
    end

endmodule

`default_nettype wire

@@ hdl/battery_level_curve_interpolator_unit.sv @@
// Top level of the battery level interpolator: config registers, controller and datapath.
//
// Usage:
//  - Input channel (i_in_valid / o_in_ready) takes one word per handshake. Action
//    write-charge or write-discharge stores a curve point (voltage, level) at
//    i_point_index; action query looks up i_query_voltage on the curve picked by
//    i_charging. Action three is dropped.
//  - Config channel (i_cfg_valid / o_cfg_ready, always ready) sets the point counts:
//    index 0 charging curve, index 1 discharging curve. Write only while idle.
//  - Output channel (o_out_valid / i_out_ready) carries one level word per query.
//  - A write leaves the controller idle; the next word is taken on the following edge.
//  - A query reads the first and last points, then scans with one RAM read per
//    point, then does one multiply and a 24-step restoring divide before
//    o_out_valid; a single point skips scan and divide, a zero span skips the divide.
//  - One query is in flight at a time; o_in_ready drops until its result is loaded.
//  - The result sits in an output register, so the next word is accepted while it
//    waits; a later query holds its result until the register is free.
//  - Reset clears both point counts to one and empties the output; curve RAM is
//    not cleared and must be written before use.
`default_nettype none

module battery_level_curve_interpolator_unit
    import blci_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // item input
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic [ACT_W-1:0]        i_action,
    input  wire logic [IDX_W-1:0]        i_point_index,
    input  wire logic [VOLT_W-1:0]       i_point_voltage,
    input  wire logic signed [LVL_W-1:0] i_point_level,
    input  wire logic [VOLT_W-1:0]       i_query_voltage,
    input  wire logic                    i_charging,
    // result output
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic [OUT_W-1:0]             o_level,
    // config writes
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [CFG_W-1:0]        i_cfg_data
);

    logic [CFG_W-1:0] r_charge_points;
    logic [CFG_W-1:0] r_discharge_points;
    logic [CNT_W-1:0] sel_count;
    t_cmd             cmd;
    t_status          status;

    assign o_cfg_ready = 1'b1;

    // Point counts; writes beyond the register list fall through.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_charge_points    <= CFG_W'(1);
            r_discharge_points <= CFG_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CHARGE_POINTS:    r_charge_points    <= i_cfg_data;
                CFG_DISCHARGE_POINTS: r_discharge_points <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Effective count for the curve the query selects, latched by the controller.
    assign sel_count = (i_charging == CURVE_CHARGE) ? f_eff_count(r_charge_points)
                                                    : f_eff_count(r_discharge_points);

    blci_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_n         (sel_count),
        .i_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    blci_datapath u_datapath (
        .i_clk           (i_clk),
        .i_cmd           (cmd),
        .i_action        (i_action),
        .i_point_index   (i_point_index),
        .i_point_voltage (i_point_voltage),
        .i_point_level   (i_point_level),
        .i_query_voltage (i_query_voltage),
        .i_charging      (i_charging),
        .o_status        (status),
        .o_level         (o_level)
    );

endmodule

`default_nettype wire

@@ hdl/blci_checker.sv @@
// Port-level checker for the battery level interpolator, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module blci_checker
    import blci_pkg::*;
(
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_in_valid,
    input wire logic                    o_in_ready,
    input wire logic [ACT_W-1:0]        i_action,
    input wire logic                    o_out_valid,
    input wire logic                    i_out_ready,
    input wire logic [OUT_W-1:0]        o_level
);

    `ASSERT_ALWAYS(a_reset_empties_out, i_clk, !i_rst_n |=> !o_out_valid, "output valid after reset")
    `ASSERT_CLKD(a_level_range, i_clk, i_rst_n, o_out_valid |-> (o_level <= OUT_W'(LEVEL_MAX)), "level above 100")
    `ASSERT_CLKD(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_level), "stalled result changed")
    `ASSERT_CLKD(a_query_busy, i_clk, i_rst_n, i_in_valid && o_in_ready && (i_action == ACT_QUERY) |=> !o_in_ready, "ready straight after a query")
    `ASSERT_CLKD(a_write_one_cycle, i_clk, i_rst_n, i_in_valid && o_in_ready && (i_action != ACT_QUERY) |=> o_in_ready, "write held the input")

endmodule

bind battery_level_curve_interpolator_unit blci_checker u_checker (.*);

`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking testbench for the battery level curve interpolator unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import blci_pkg::*;

    localparam int CLK_HALF         = 5;
    localparam int RESET_CYCLES     = 12;
    // Pause after the last level comes back, so any word still in flight is done
    localparam int SETTLE_CYCLES    = 60;
    localparam int CYCLE_LIMIT      = 500000;
    localparam int NUM_PHASES       = 6;
    localparam int PHASE_WORDS      = 113;
    localparam int SINK_HOLD_CYCLES = 400;
    localparam int MISMATCH_PRINTS  = 100;

    // One input word, every field on a port of its own
    typedef struct {
        logic [ACT_W-1:0]        action;
        logic [IDX_W-1:0]        index;
        logic [VOLT_W-1:0]       pt_volts;
        logic signed [LVL_W-1:0] pt_level;
        logic [VOLT_W-1:0]       query_volts;
        logic                    charging;
    } t_curve_word;

    // Shadow of both curves and point counts; works out the level each lookup should give
    class curve_level_scoreboard;
        logic [VOLT_W-1:0]       volt_tab  [2][MAX_POINTS];
        logic signed [LVL_W-1:0] lvl_tab   [2][MAX_POINTS];
        bit                      loaded    [2][MAX_POINTS];
        logic [CFG_W-1:0]        point_reg [2];
        logic [OUT_W-1:0]        pending_levels [$];
        int mismatches;
        int levels_checked;
        int lookups;
        int point_writes;
        int dropped;

        function new();
            point_reg[CURVE_CHARGE]    = CFG_W'(1);
            point_reg[CURVE_DISCHARGE] = CFG_W'(1);
            foreach (loaded[c, p]) loaded[c][p] = 1'b0;
            mismatches     = 0;
            levels_checked = 0;
            lookups        = 0;
            point_writes   = 0;
            dropped        = 0;
        endfunction

        function void set_points(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == CFG_CHARGE_POINTS) begin
                point_reg[CURVE_CHARGE] = data;
            end else begin
                point_reg[CURVE_DISCHARGE] = data;
            end
        endfunction

        // Zero counts as one point, anything past the table saturates
        function int used_points(logic curve);
            int n;
            n = int'(point_reg[curve]);
            if (n == 0) begin
                n = 1;
            end else if (n > MAX_POINTS) begin
                n = MAX_POINTS;
            end
            return n;
        endfunction

        // Lowest point in use that has never been loaded, or -1
        function int first_unloaded(logic curve);
            int gap;
            gap = -1;
            for (int p = used_points(curve) - 1; p >= 0; p--) begin
                if (!loaded[curve][p]) gap = p;
            end
            return gap;
        endfunction

        function logic [OUT_W-1:0] lookup_level(logic curve, logic [VOLT_W-1:0] volts);
            int     n;
            longint v;
            longint v_lo;
            longint v_hi;
            longint l_lo;
            longint l_hi;
            longint span;
            longint lvl;
            bit     found;
            n    = used_points(curve);
            v    = {48'd0, volts};
            lvl  = lvl_tab[curve][0];
            v_lo = {48'd0, volt_tab[curve][0]};
            v_hi = {48'd0, volt_tab[curve][n-1]};
            // Clamp to first point, else to last; with a falling curve the last can sit lower
            if (v < v_lo) begin
                v = v_lo;
            end else if (v > v_hi) begin
                v = v_hi;
            end
            found = 1'b0;
            for (int p = 1; p < n && !found; p++) begin
                v_hi = {48'd0, volt_tab[curve][p]};
                if (v < v_hi) begin
                    v_lo = {48'd0, volt_tab[curve][p-1]};
                    l_lo = lvl_tab[curve][p-1];
                    l_hi = lvl_tab[curve][p];
                    span = v_hi - v_lo;
                    // Equal neighbours: take the lower point, no divide
                    if (span == 0) begin
                        lvl = l_lo;
                    end else begin
                        lvl = l_lo + (l_hi - l_lo) * (v - v_lo) / span;
                    end
                    found = 1'b1;
                end else begin
                    lvl = lvl_tab[curve][p];
                end
            end
            if (lvl < 0) begin
                lvl = 0;
            end else if (lvl > LEVEL_MAX) begin
                lvl = LEVEL_MAX;
            end
            return OUT_W'(lvl);
        endfunction

        function void note_word(t_curve_word w);
            logic curve;
            case (w.action)
                ACT_WR_CHARGE, ACT_WR_DISCHARGE: begin
                    curve = (w.action == ACT_WR_CHARGE) ? CURVE_CHARGE : CURVE_DISCHARGE;
                    if (int'(w.index) < MAX_POINTS) begin
                        volt_tab[curve][w.index] = w.pt_volts;
                        lvl_tab[curve][w.index]  = w.pt_level;
                        loaded[curve][w.index]   = 1'b1;
                    end
                    point_writes++;
                end
                ACT_QUERY: begin
                    curve = w.charging ? CURVE_CHARGE : CURVE_DISCHARGE;
                    pending_levels.push_back(lookup_level(curve, w.query_volts));
                    lookups++;
                end
                default: begin
                    dropped++;
                end
            endcase
        endfunction

        task report_mismatch(string what);
            if (mismatches < MISMATCH_PRINTS) $display("MISMATCH @%0t: %s", $time, what);
            mismatches++;
        endtask

        task check_level(logic [OUT_W-1:0] got);
            logic [OUT_W-1:0] want;
            levels_checked++;
            if (pending_levels.size() == 0) begin
                report_mismatch($sformatf("level %0d with no lookup outstanding", got));
            end else begin
                want = pending_levels.pop_front();
                if (got !== want) begin
                    report_mismatch($sformatf("lookup %0d: level %0d, expected %0d",
                                              levels_checked, got, want));
                end
            end
        endtask
    endclass

    // Clock, reset and every block input start at known values
    logic                    i_clk           = 1'b0;
    logic                    i_rst_n         = 1'b0;
    logic                    i_in_valid      = 1'b0;
    logic [ACT_W-1:0]        i_action        = ACT_NONE;
    logic [IDX_W-1:0]        i_point_index   = '0;
    logic [VOLT_W-1:0]       i_point_voltage = '0;
    logic signed [LVL_W-1:0] i_point_level   = '0;
    logic [VOLT_W-1:0]       i_query_voltage = '0;
    logic                    i_charging      = 1'b0;
    logic                    i_out_ready     = 1'b0;
    logic                    i_cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index     = '0;
    logic [CFG_W-1:0]        i_cfg_data      = '0;
    logic                    o_in_ready;
    logic                    o_out_valid;
    logic [OUT_W-1:0]        o_level;
    logic                    o_cfg_ready;

    curve_level_scoreboard sb;
    int unsigned cycle_count   = 0;
    int          src_idle_pct  = 21;
    int          sink_idle_pct = 79;
    bit          sink_hold_req = 1'b0;
    int          sink_hold_left = 0;
    int          cfg_writes    = 0;

    // Point count settings, one pair per random phase; extremes and out-of-range values included
    logic [CFG_W-1:0] charge_setting    [NUM_PHASES] = '{5'd16, 5'd2, 5'd0, 5'd16, 5'd5, 5'd13};
    logic [CFG_W-1:0] discharge_setting [NUM_PHASES] = '{5'd16, 5'd31, 5'd9, 5'd1, 5'd16, 5'd3};

    battery_level_curve_interpolator_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_point_index   (i_point_index),
        .i_point_voltage (i_point_voltage),
        .i_point_level   (i_point_level),
        .i_query_voltage (i_query_voltage),
        .i_charging      (i_charging),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_level         (o_level),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Watchdog: a hang anywhere ends the run as a failure
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d levels outstanding",
                     cycle_count, sb.pending_levels.size());
            $display("battery_level_curve_interpolator_unit test failed");
            $finish;
        end
    end

    // Result side: random back-pressure, plus one long hold-off on request so the
    // output register fills, the lookup behind it stalls and o_in_ready drops
    always @(negedge i_clk) begin
        if (sink_hold_req) begin
            sink_hold_left = SINK_HOLD_CYCLES;
            sink_hold_req  = 1'b0;
        end
        if (sink_hold_left > 0) begin
            sink_hold_left--;
            i_out_ready = 1'b0;
        end else begin
            i_out_ready = ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Every level word taken is checked against the oldest expected level
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_level(o_level);
    end

    // Offer one word, with random idle cycles before it; note it once taken
    task automatic send_word(input t_curve_word w);
        while ($urandom_range(99) < src_idle_pct) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid      = 1'b1;
        i_action        = w.action;
        i_point_index   = w.index;
        i_point_voltage = w.pt_volts;
        i_point_level   = w.pt_level;
        i_query_voltage = w.query_volts;
        i_charging      = w.charging;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_word(w);
    endtask

    task automatic sender_rest();
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic wait_for_levels();
        while (sb.pending_levels.size() != 0) @(posedge i_clk);
    endtask

    // Idle the block: no words offered, all levels back, trailing point writes done
    task automatic settle();
        sender_rest();
        wait_for_levels();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_points(idx, data);
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Fully random word; fields an action does not use still carry random bits
    function automatic t_curve_word noise_word();
        t_curve_word w;
        w.action      = ACT_W'($urandom_range(3));
        w.index       = IDX_W'($urandom_range(MAX_POINTS - 1));
        w.pt_volts    = VOLT_W'($urandom);
        w.pt_level    = LVL_W'($urandom);
        w.query_volts = VOLT_W'($urandom);
        w.charging    = 1'($urandom_range(1));
        return w;
    endfunction

    function automatic t_curve_word point_word(logic curve, int idx, int volts, int lvl);
        t_curve_word w;
        w          = noise_word();
        w.action   = (curve == CURVE_CHARGE) ? ACT_WR_CHARGE : ACT_WR_DISCHARGE;
        w.index    = IDX_W'(idx);
        w.pt_volts = VOLT_W'(volts);
        w.pt_level = LVL_W'(lvl);
        return w;
    endfunction

    function automatic t_curve_word lookup_word(logic curve, int volts);
        t_curve_word w;
        w             = noise_word();
        w.action      = ACT_QUERY;
        w.query_volts = VOLT_W'(volts);
        w.charging    = (curve == CURVE_CHARGE);
        return w;
    endfunction

    // Mostly a rising curve with rising levels (some beyond 0..100), now and then an
    // equal neighbour voltage or an arbitrary point that breaks the ordering
    function automatic t_curve_word shaped_point(logic curve, int idx);
        int volts;
        int lvl;
        int r;
        r     = $urandom_range(99);
        volts = 2800 + idx * 80 + int'($urandom_range(60));
        lvl   = idx * 7 - 5 + int'($urandom_range(6));
        if (r < 6 && idx > 0 && sb.loaded[curve][idx-1]) begin
            volts = sb.volt_tab[curve][idx-1];
        end else if (r < 18) begin
            volts = $urandom_range(65535);
            lvl   = int'($urandom_range(255)) - 128;
        end
        return point_word(curve, idx, volts, lvl);
    endfunction

    // Lookup voltage: around the curve span, on a point, beside one, or anywhere
    function automatic int pick_query_volts(logic curve);
        int n;
        int a;
        int b;
        int lo;
        int hi;
        int k;
        int r;
        n  = sb.used_points(curve);
        a  = sb.volt_tab[curve][0];
        b  = sb.volt_tab[curve][n-1];
        lo = ((a < b) ? a : b) - 100;
        hi = ((a < b) ? b : a) + 100;
        if (lo < 0) lo = 0;
        if (hi > 65535) hi = 65535;
        k  = $urandom_range(n - 1);
        r  = $urandom_range(99);
        if (r < 35) return $urandom_range(hi, lo);
        if (r < 55) return sb.volt_tab[curve][k];
        if (r < 65) return (int'(sb.volt_tab[curve][k]) + ($urandom_range(1) ? 1 : -1)) & 16'hFFFF;
        if (r < 75) return $urandom_range(1) ? 65535 : 0;
        return $urandom_range(65535);
    endfunction

    // A lookup is only issued once every point in use on that curve has been loaded;
    // until then the lookup slot goes to loading the lowest missing point
    function automatic t_curve_word random_word();
        t_curve_word w;
        logic        curve;
        int          r;
        int          gap;
        r     = $urandom_range(99);
        curve = 1'($urandom_range(1));
        if (r < 5) begin
            w        = noise_word();
            w.action = ACT_NONE;
        end else if (r < 38) begin
            w = shaped_point(curve, $urandom_range(MAX_POINTS - 1));
        end else begin
            gap = sb.first_unloaded(curve);
            if (gap >= 0) begin
                w = shaped_point(curve, gap);
            end else begin
                w = lookup_word(curve, pick_query_volts(curve));
            end
        end
        return w;
    endfunction

    initial begin : stimulus
        t_curve_word w;
        int          useful;
        sb = new();

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed, reset point counts of one: single-point curves at the extremes
        send_word(point_word(CURVE_CHARGE, 0, 65535, 127));
        send_word(point_word(CURVE_DISCHARGE, 0, 0, -128));
        send_word(lookup_word(CURVE_CHARGE, 0));
        send_word(lookup_word(CURVE_CHARGE, 65535));
        send_word(lookup_word(CURVE_DISCHARGE, 65535));
        send_word(lookup_word(CURVE_DISCHARGE, 0));
        // Action three is dropped without a level word
        w        = noise_word();
        w.action = ACT_NONE;
        send_word(w);

        // Count of zero reads as one; discharge curve falls back below its first point,
        // so the clamp lands between two equal voltages and the divide is skipped
        settle();
        write_register(CFG_CHARGE_POINTS, CFG_W'(0));
        write_register(CFG_DISCHARGE_POINTS, CFG_W'(3));
        send_word(lookup_word(CURVE_CHARGE, 12345));
        send_word(point_word(CURVE_DISCHARGE, 0, 5000, 40));
        send_word(point_word(CURVE_DISCHARGE, 1, 5000, 90));
        send_word(point_word(CURVE_DISCHARGE, 2, 1000, 10));
        send_word(lookup_word(CURVE_DISCHARGE, 2000));
        send_word(lookup_word(CURVE_DISCHARGE, 65535));

        // Four charging points: equal neighbours, a falling last segment that makes
        // the quotient negative (truncation toward zero), a last level below zero
        settle();
        write_register(CFG_CHARGE_POINTS, CFG_W'(4));
        write_register(CFG_DISCHARGE_POINTS, CFG_W'(31));
        send_word(point_word(CURVE_CHARGE, 0, 3000, 0));
        send_word(point_word(CURVE_CHARGE, 1, 3500, 50));
        send_word(point_word(CURVE_CHARGE, 2, 3500, 70));
        send_word(point_word(CURVE_CHARGE, 3, 4200, -20));
        send_word(lookup_word(CURVE_CHARGE, 3250));
        send_word(lookup_word(CURVE_CHARGE, 3500));
        send_word(lookup_word(CURVE_CHARGE, 3999));
        send_word(lookup_word(CURVE_CHARGE, 4200));
        send_word(lookup_word(CURVE_CHARGE, 2999));
        send_word(lookup_word(CURVE_CHARGE, 3001));

        // Random phases: new point counts each time, idling first mostly on the result
        // side, then mostly on the input side, then none at all
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            write_register(CFG_CHARGE_POINTS, charge_setting[ph]);
            write_register(CFG_DISCHARGE_POINTS, discharge_setting[ph]);
            if (ph < 2) begin
                src_idle_pct  = 21;
                sink_idle_pct = 79;
            end else if (ph < 4) begin
                src_idle_pct  = 79;
                sink_idle_pct = 21;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            // Long result stall while words keep coming
            if (ph == 1) sink_hold_req = 1'b1;
            useful = 0;
            while (useful < PHASE_WORDS) begin
                w = random_word();
                send_word(w);
                if (w.action != ACT_NONE) useful++;
                // Input side goes quiet until every level is back
                if (ph == 3 && useful == PHASE_WORDS / 2) begin
                    sender_rest();
                    wait_for_levels();
                end
            end
        end

        settle();
        $display("Covered %0d lookups, %0d point writes, %0d dropped words, %0d register writes",
                 sb.lookups, sb.point_writes, sb.dropped, cfg_writes);
        $display("Levels compared: %0d, mismatches: %0d", sb.levels_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_levels.size() == 0) begin
            $display("battery_level_curve_interpolator_unit test passed");
        end else begin
            $display("battery_level_curve_interpolator_unit test failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/blci_pkg.sv
hdl/blci_ram.sv
hdl/blci_datapath.sv
hdl/blci_ctrl.sv
hdl/battery_level_curve_interpolator_unit.sv
hdl/blci_checker.sv
verif/testbench.sv
